FILE: rtl/core/lcs_pkg.sv
// Shared types and constants for the LCS length engine.
`timescale 1ns / 1ps
package lcs_pkg;

	localparam int SYM_W = 8;
	localparam int LEN_W = 6;

	typedef enum logic {
		OP_LOAD,
		OP_TEXT
	} op_t;

	// Control that travels with each token down the cell chain.
	typedef struct packed {
		logic valid;
		op_t  op;
		logic clr;   // zero the row before a pattern load
		logic last;  // last text symbol: zero the row after the update
		logic ovf;   // overflow flag captured at intake
	} ctrl_t;

endpackage

FILE: rtl/core/lcs_length_engine.sv
// Top level of the LCS length engine: intake control, cell chain, result register.
`timescale 1ns / 1ps
// Computes the length of the longest common subsequence of a pattern and a text,
// both byte strings. Send pattern bytes with tuser = 0 (tlast on the final one),
// then text bytes with tuser = 1; tlast on the final text byte yields one result
// transfer and clears the engine for the next pair. Pattern bytes beyond MAX_LEN
// are dropped and reported in the result's tuser. A pattern byte that follows
// text or a finished pattern starts a new pair. Every byte flows through a chain
// of MAX_LEN cells, one cell per pattern position, as a diagonal wavefront, so
// one transfer is taken per clock; the result passes through every cell register
// and then the output register. Input is held off only while a result sits at
// the end of the chain and the output register is full and not being drained.
module lcs_length_engine #(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] symbol
	input  logic       s_axis_tuser,   // [0] string_sel
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [5:0] lcs_length, [7:6] zero
	output logic       m_axis_tuser    // [0] pattern_overflow
);
	import lcs_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

	ctrl_t            ch_ctrl [0:MAX_LEN];
	logic [SYM_W-1:0] ch_sym  [0:MAX_LEN];
	logic [CW-1:0]    ch_cnt  [0:MAX_LEN];
	logic [CW-1:0]    ch_left [0:MAX_LEN];
	logic [CW-1:0]    ch_diag [0:MAX_LEN];
	logic [CW-1:0]    ch_res  [0:MAX_LEN];

	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             done_q;
	logic             out_valid_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_ovf_q;

	logic             adv;
	logic             in_fire;
	logic             is_text;
	logic             clr_now;
	logic [CW-1:0]    cnt_eff;
	logic             room;
	logic             tail_result;
	logic [LEN_W-1:0] tail_len;

	// intake
	assign is_text = s_axis_tuser;
	assign clr_now = !is_text && done_q;
	assign cnt_eff = clr_now ? '0 : cnt_q;
	assign room    = cnt_eff < MAX_CNT;

	assign tail_result = ch_ctrl[MAX_LEN].valid && (ch_ctrl[MAX_LEN].op == OP_TEXT) &&
	                     ch_ctrl[MAX_LEN].last;
	assign adv           = !(out_valid_q && !m_axis_tready && tail_result);
	assign s_axis_tready = adv;
	assign in_fire       = s_axis_tvalid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (in_fire) begin
			if (is_text) begin
				if (s_axis_tlast) begin
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b1;
				end
			end else begin
				done_q <= s_axis_tlast;
				if (room) begin
					cnt_q <= cnt_eff + CW'(1);
					ovf_q <= clr_now ? 1'b0 : ovf_q;
				end else begin
					cnt_q <= cnt_eff;
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		ch_ctrl[0].valid = in_fire;
		ch_ctrl[0].op    = is_text ? OP_TEXT : OP_LOAD;
		ch_ctrl[0].clr   = clr_now;
		ch_ctrl[0].last  = s_axis_tlast;
		ch_ctrl[0].ovf   = ovf_q;
	end

	assign ch_sym[0]  = s_axis_tdata;
	assign ch_cnt[0]  = is_text ? cnt_q : cnt_eff;
	assign ch_left[0] = '0;
	assign ch_diag[0] = '0;
	assign ch_res[0]  = '0;

	// cell chain
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		lcs_cell #(
			.MAX_LEN(MAX_LEN),
			.J      (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctrl_in(ch_ctrl[i]),
			.sym_in (ch_sym[i]),
			.cnt_in (ch_cnt[i]),
			.left_in(ch_left[i]),
			.diag_in(ch_diag[i]),
			.res_in (ch_res[i]),
			.ctrl_q (ch_ctrl[i+1]),
			.sym_q  (ch_sym[i+1]),
			.cnt_q  (ch_cnt[i+1]),
			.left_q (ch_left[i+1]),
			.diag_q (ch_diag[i+1]),
			.res_q  (ch_res[i+1])
		);
	end

	if (CW >= LEN_W) begin : g_trunc
		assign tail_len = ch_res[MAX_LEN][LEN_W-1:0];
	end else begin : g_ext
		assign tail_len = {{(LEN_W - CW){1'b0}}, ch_res[MAX_LEN]};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && tail_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_result) begin
			out_len_q <= tail_len;
			out_ovf_q <= ch_ctrl[MAX_LEN].ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8 - LEN_W){1'b0}}, out_len_q};
	assign m_axis_tuser  = out_ovf_q;

`ifndef SYNTHESIS
	a_stall_only_on_blocked_result : assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_count_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("pattern count beyond capacity");

	a_overflow_only_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == MAX_CNT))
		else $error("overflow flagged before pattern store was full");

	a_result_loads_output : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tail_result) |=> m_axis_tvalid)
		else $error("result from chain not captured");
`endif

endmodule

FILE: rtl/core/lcs_cell.sv
// One cell of the LCS chain: one pattern symbol and one row entry.
`timescale 1ns / 1ps
module lcs_cell #(
	parameter int MAX_LEN = 32,
	parameter int J = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  lcs_pkg::ctrl_t                   ctrl_in,
	input  logic [lcs_pkg::SYM_W-1:0]        sym_in,
	input  logic [$clog2(MAX_LEN+1)-1:0]     cnt_in,
	input  logic [$clog2(MAX_LEN+1)-1:0]     left_in,
	input  logic [$clog2(MAX_LEN+1)-1:0]     diag_in,
	input  logic [$clog2(MAX_LEN+1)-1:0]     res_in,
	output lcs_pkg::ctrl_t                   ctrl_q,
	output logic [lcs_pkg::SYM_W-1:0]        sym_q,
	output logic [$clog2(MAX_LEN+1)-1:0]     cnt_q,
	output logic [$clog2(MAX_LEN+1)-1:0]     left_q,
	output logic [$clog2(MAX_LEN+1)-1:0]     diag_q,
	output logic [$clog2(MAX_LEN+1)-1:0]     res_q
);
	import lcs_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] POS      = CW'(J);
	localparam logic [CW-1:0] POS_NEXT = CW'(J + 1);

	logic [SYM_W-1:0] pat_q;
	logic [CW-1:0]    row_q;
	logic             active;
	logic [CW-1:0]    cell_val;
	logic             take;

	assign take     = en && ctrl_in.valid;
	assign active   = (ctrl_in.op == OP_TEXT) && (cnt_in > POS);
	assign cell_val = (pat_q == sym_in) ? (diag_in + CW'(1)) :
	                  ((row_q >= left_in) ? row_q : left_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (take) begin
			if (ctrl_in.op == OP_LOAD) begin
				if (ctrl_in.clr)
					row_q <= '0;
			end else if (ctrl_in.last) begin
				row_q <= '0;
			end else if (active) begin
				row_q <= cell_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctrl_in.op == OP_LOAD && cnt_in == POS)
			pat_q <= sym_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sym_q  <= sym_in;
			cnt_q  <= cnt_in;
			left_q <= active ? cell_val : left_in;
			diag_q <= row_q;
			res_q  <= (active && cnt_in == POS_NEXT) ? cell_val : res_in;
		end
	end

endmodule

FILE: test/lcs_length_engine_tb.sv
// Self-checking testbench for lcs_length_engine: directed and random pattern/text pairs against a software row model.
`timescale 1ns / 1ps
module lcs_length_engine_tb;
	import lcs_pkg::*;

	localparam int MAX_LEN = 32;
	localparam int QUIET_ITEMS = 150;

	typedef struct {
		op_t              op;
		logic [SYM_W-1:0] sym;
		logic             last;
	} symbol_item_t;

	typedef struct {
		logic [LEN_W-1:0] length;
		logic             overflow;
	} lcs_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;   // [7:0] symbol
	logic             s_axis_tuser = 1'b0; // [0] string_sel
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;        // [5:0] lcs_length, [7:6] zero
	logic             m_axis_tuser;        // [0] pattern_overflow

	symbol_item_t     symbol_q[$];
	lcs_result_t      lcs_expected_q[$];
	symbol_item_t     cur_item;
	logic             calm = 1'b0;
	int               in_gap = 0;
	int               out_hold = 0;
	int               mismatch_count = 0;

	// software copy of the engine state
	logic [SYM_W-1:0] pat_mem [MAX_LEN];
	int unsigned      pat_len = 0;
	logic [LEN_W-1:0] lcs_row [MAX_LEN];
	logic             pat_overflow = 1'b0;
	logic             pat_closed = 1'b0;

	lcs_length_engine #(.MAX_LEN(MAX_LEN)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_pair();
		foreach (lcs_row[i]) lcs_row[i] = '0;
		pat_len = 0;
		pat_overflow = 1'b0;
		pat_closed = 1'b0;
	endfunction

	task automatic apply_symbol(input symbol_item_t it);
		int unsigned diag, left, up, next_val;
		lcs_result_t res;
		if (it.op == OP_LOAD) begin
			if (pat_closed)
				clear_pair();
			if (pat_len < MAX_LEN) begin
				pat_mem[pat_len] = it.sym;
				pat_len++;
			end else begin
				pat_overflow = 1'b1;
			end
			if (it.last)
				pat_closed = 1'b1;
		end else begin
			pat_closed = 1'b1;
			diag = 0;
			left = 0;
			for (int j = 0; j < pat_len; j++) begin
				up = lcs_row[j];
				if (pat_mem[j] == it.sym)
					next_val = diag + 1;
				else
					next_val = (up >= left) ? up : left;
				diag = up;
				lcs_row[j] = next_val[LEN_W-1:0];
				left = next_val;
			end
			if (it.last) begin
				res.length = (pat_len > 0) ? lcs_row[pat_len-1] : '0;
				res.overflow = pat_overflow;
				lcs_expected_q.push_back(res);
				clear_pair();
			end
		end
	endtask

	task automatic push_symbol(input op_t op, input logic [7:0] sym, input logic last);
		symbol_item_t it;
		it.op = op;
		it.sym = sym;
		it.last = last;
		symbol_q.push_back(it);
	endtask

	// one pattern/text pair, mostly well formed; some drop a tlast mark
	task automatic push_random_pair();
		logic [7:0] pat[$];
		logic [7:0] base, sym;
		int kind, plen, tlen;
		bit wide, mirror, pat_mark, text_mark;
		kind = $urandom_range(0, 99);
		if (kind < 5)
			plen = 0;
		else if (kind < 12)
			plen = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
		else if (kind < 22)
			plen = $urandom_range(20, MAX_LEN);
		else
			plen = $urandom_range(1, 8);
		base = 8'($urandom_range(0, 255));
		wide = ($urandom_range(0, 3) == 0);
		mirror = ($urandom_range(0, 2) == 0);
		pat_mark = ($urandom_range(0, 9) != 0);
		text_mark = ($urandom_range(0, 11) != 0);
		for (int i = 0; i < plen; i++) begin
			sym = wide ? 8'($urandom_range(0, 255)) : base ^ 8'($urandom_range(0, 3));
			pat.push_back(sym);
			push_symbol(OP_LOAD, sym, pat_mark && (i == plen - 1));
		end
		if (mirror && plen > 0)
			tlen = plen;
		else if ($urandom_range(0, 4) == 0)
			tlen = $urandom_range(1, MAX_LEN + 8);
		else
			tlen = $urandom_range(1, 12);
		for (int i = 0; i < tlen; i++) begin
			if (mirror && i < pat.size())
				sym = pat[i];
			else
				sym = wide ? 8'($urandom_range(0, 255)) : base ^ 8'($urandom_range(0, 3));
			push_symbol(OP_TEXT, sym, text_mark && (i == tlen - 1));
		end
	endtask

	// driver
	always @(posedge clk) begin
		logic v;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_symbol(cur_item);
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				v = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (symbol_q.size() == 0) begin
					v = 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 7);
				end else begin
					cur_item = symbol_q.pop_front();
					v = 1'b1;
					s_axis_tdata <= cur_item.sym;
					s_axis_tuser <= cur_item.op;
					s_axis_tlast <= cur_item.last;
				end
				s_axis_tvalid <= v;
			end
			calm <= (symbol_q.size() < QUIET_ITEMS);
		end
	end

	// monitor
	always @(posedge clk) begin
		lcs_result_t exp_res;
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (lcs_expected_q.size() == 0) begin
					$error("result transfer with no expectation: lcs_length %0d, pattern_overflow %0b",
						m_axis_tdata[5:0], m_axis_tuser);
					mismatch_count++;
				end else begin
					exp_res = lcs_expected_q.pop_front();
					if (m_axis_tdata[5:0] !== exp_res.length) begin
						$error("lcs_length: expected %0d, actual %0d", exp_res.length,
							m_axis_tdata[5:0]);
						mismatch_count++;
					end
					if (m_axis_tuser !== exp_res.overflow) begin
						$error("pattern_overflow: expected %0b, actual %0b", exp_res.overflow,
							m_axis_tuser);
						mismatch_count++;
					end
				end
			end
			rdy = 1'b1;
			if (out_hold > 0) begin
				out_hold--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_hold = $urandom_range(0, 7);
				rdy = 1'b0;
			end
			m_axis_tready <= rdy;
		end
	end

	initial begin
		// empty pattern
		push_symbol(OP_TEXT, 8'h41, 1'b1);
		// single-symbol pair at the low extreme
		push_symbol(OP_LOAD, 8'h00, 1'b1);
		push_symbol(OP_TEXT, 8'h00, 1'b1);
		// crossed extremes
		push_symbol(OP_LOAD, 8'hFF, 1'b0);
		push_symbol(OP_LOAD, 8'h00, 1'b1);
		push_symbol(OP_TEXT, 8'h00, 1'b0);
		push_symbol(OP_TEXT, 8'hFF, 1'b1);
		// text arrives before the pattern is marked last
		push_symbol(OP_LOAD, 8'hAA, 1'b0);
		push_symbol(OP_TEXT, 8'hAA, 1'b1);
		// a pattern symbol after a finished pattern starts a new pair
		push_symbol(OP_LOAD, 8'h12, 1'b1);
		push_symbol(OP_LOAD, 8'h34, 1'b1);
		push_symbol(OP_TEXT, 8'h34, 1'b1);
		// a pattern symbol after unfinished text starts a new pair
		push_symbol(OP_LOAD, 8'h55, 1'b1);
		push_symbol(OP_TEXT, 8'h55, 1'b0);
		push_symbol(OP_LOAD, 8'h66, 1'b1);
		push_symbol(OP_TEXT, 8'h55, 1'b1);
		// reordered text
		push_symbol(OP_LOAD, 8'h01, 1'b0);
		push_symbol(OP_LOAD, 8'h02, 1'b0);
		push_symbol(OP_LOAD, 8'h03, 1'b1);
		push_symbol(OP_TEXT, 8'h03, 1'b0);
		push_symbol(OP_TEXT, 8'h02, 1'b0);
		push_symbol(OP_TEXT, 8'h01, 1'b0);
		push_symbol(OP_TEXT, 8'h02, 1'b0);
		push_symbol(OP_TEXT, 8'h03, 1'b1);
		while (symbol_q.size() < 1800)
			push_random_pair();
		// close any pair left open so its result is checked
		push_symbol(OP_TEXT, 8'h00, 1'b1);

		clear_pair();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (symbol_q.size() != 0 || s_axis_tvalid || lcs_expected_q.size() != 0)
			@(posedge clk);
		repeat (MAX_LEN + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: lcs_length_engine.f
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/lcs_length_engine.sv
test/lcs_length_engine_tb.sv
